[hdl/pbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse period to BPM display: shared package
// Widths, reset constants, the result record passed from the rate unit and
// the seven-segment decode used on the output.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int TPM_W           = 32;
    localparam int PERIOD_W        = 24;
    localparam int RATE_W          = 10;
    localparam int DIGIT_W         = 4;
    localparam int SEG_W           = 7;

    localparam logic [TPM_W-1:0]   TPM_RESET = 32'd110592000;
    localparam logic [RATE_W-1:0]  RATE_MAX  = 10'd999;

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } pbd_result_t;

    typedef struct packed {
        logic start;
        logic take;
    } pbd_ctrl_t;

    typedef struct packed {
        logic done;
    } pbd_status_t;

    // Active-low segments, bit 0 is segment a and bit 6 is segment g.
    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        begin
            case (d)
                4'd0:    s = 7'h40;
                4'd1:    s = 7'h79;
                4'd2:    s = 7'h24;
                4'd3:    s = 7'h30;
                4'd4:    s = 7'h19;
                4'd5:    s = 7'h12;
                4'd6:    s = 7'h02;
                4'd7:    s = 7'h78;
                4'd8:    s = 7'h00;
                4'd9:    s = 7'h10;
                default: s = 7'h7F;
            endcase
            return s;
        end
    endfunction

endpackage

[hdl/pbd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse period to BPM display: channel interfaces
// Valid/ready channels for the pulse samples and for the measurement results.
// ----------------------------------------------------------------------------
interface pbd_in_if;
    logic valid;
    logic ready;
    logic pulse_level;

    modport source (output valid, output pulse_level, input ready);
    modport sink   (input valid, input pulse_level, output ready);
endinterface

interface pbd_out_if;
    logic                           valid;
    logic                           ready;
    logic [pbd_pkg::PERIOD_W-1:0]   period_ticks;
    logic [pbd_pkg::RATE_W-1:0]     beats_per_minute;
    logic [pbd_pkg::DIGIT_W-1:0]    digit_hundreds;
    logic [pbd_pkg::DIGIT_W-1:0]    digit_tens;
    logic [pbd_pkg::DIGIT_W-1:0]    digit_ones;
    logic [pbd_pkg::SEG_W-1:0]      segments_hundreds;
    logic [pbd_pkg::SEG_W-1:0]      segments_tens;
    logic [pbd_pkg::SEG_W-1:0]      segments_ones;

    modport source (output valid, output period_ticks, output beats_per_minute,
                    output digit_hundreds, output digit_tens, output digit_ones,
                    output segments_hundreds, output segments_tens,
                    output segments_ones, input ready);
    modport sink   (input valid, input period_ticks, input beats_per_minute,
                    input digit_hundreds, input digit_tens, input digit_ones,
                    input segments_hundreds, input segments_tens,
                    input segments_ones, output ready);
endinterface

[hdl/pbd_rate_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse period to BPM display: rate unit
// One subtractor shared by a restoring divider (one quotient bit a cycle)
// and the decimal digit extraction by repeated subtraction; caps at 999.
// ----------------------------------------------------------------------------
module pbd_rate_unit #(
    parameter int COUNT_WIDTH = pbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pbd_pkg::pbd_ctrl_t        ctrl,
    input  logic [pbd_pkg::TPM_W-1:0] dividend,
    input  logic [COUNT_WIDTH-1:0]    divisor,
    output pbd_pkg::pbd_status_t      status,
    output pbd_pkg::pbd_result_t      result
);
    import pbd_pkg::*;

    localparam int SUB_W  = COUNT_WIDTH + 2;
    localparam int STEP_W = $clog2(TPM_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CAP  = 3'd2;
    localparam logic [2:0] ST_HUND = 3'd3;
    localparam logic [2:0] ST_TENS = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [STEP_W-1:0]      step_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [TPM_W-1:0]       quo_reg;
    logic [COUNT_WIDTH-1:0] dvs_reg;
    logic [RATE_W-1:0]      val_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic [DIGIT_W-1:0]     hund_reg;
    logic [DIGIT_W-1:0]     tens_reg;

    logic [SUB_W-1:0]       a_op;
    logic [SUB_W-1:0]       b_op;
    logic [SUB_W-1:0]       diff;
    logic                   borrow;

    // The shared subtractor: partial remainder against divisor, or the
    // capped rate against one hundred or ten.
    always_comb
    begin
        a_op = SUB_W'(val_reg);
        b_op = SUB_W'(10);
        unique case (state_reg)
            ST_DIV:
            begin
                a_op = {1'b0, rem_reg, quo_reg[TPM_W-1]};
                b_op = {2'b00, dvs_reg};
            end
            ST_HUND: b_op = SUB_W'(100);
            default: b_op = SUB_W'(10);
        endcase
    end

    assign diff   = a_op - b_op;
    assign borrow = diff[SUB_W-1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ctrl.start) state_next = ST_DIV;
            ST_DIV:  if (step_reg == STEP_W'(TPM_W - 1)) state_next = ST_CAP;
            ST_CAP:  state_next = ST_HUND;
            ST_HUND: if (borrow) state_next = ST_TENS;
            ST_TENS: if (borrow) state_next = ST_DONE;
            ST_DONE: if (ctrl.take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                quo_reg  <= {quo_reg[TPM_W-2:0], ~borrow};
                rem_reg  <= borrow ? a_op[COUNT_WIDTH-1:0] : diff[COUNT_WIDTH-1:0];
                step_reg <= step_reg + 1'b1;
            end
            ST_CAP:
            begin
                val_reg  <= (quo_reg > TPM_W'(RATE_MAX)) ? RATE_MAX : quo_reg[RATE_W-1:0];
                rate_reg <= (quo_reg > TPM_W'(RATE_MAX)) ? RATE_MAX : quo_reg[RATE_W-1:0];
                hund_reg <= '0;
                tens_reg <= '0;
            end
            ST_HUND:
            begin
                if (!borrow)
                begin
                    val_reg  <= diff[RATE_W-1:0];
                    hund_reg <= hund_reg + 1'b1;
                end
            end
            ST_TENS:
            begin
                if (!borrow)
                begin
                    val_reg  <= diff[RATE_W-1:0];
                    tens_reg <= tens_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.done     = (state_reg == ST_DONE);
    assign result.rate     = rate_reg;
    assign result.hundreds = hund_reg;
    assign result.tens     = tens_reg;
    assign result.ones     = val_reg[DIGIT_W-1:0];

endmodule

[hdl/pulse_period_to_bpm_display_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse period to BPM display: top level
// Measures the period between falling edges of a sampled pulse, divides the
// ticks-per-minute register by it and decodes the rate for a 3-digit display.
//
// Usage:
//   sample : one pulse_level per timebase tick, valid/ready. A transaction
//            that is not the closing falling edge of a measurement yields
//            nothing.
//   result : one transaction per measured period, carrying the period in
//            ticks, the rate (capped at 999), its decimal digits and the
//            active-low segment patterns.
//   cfg_wr_en / cfg_wr_data write ticks_per_minute; write only when idle.
//   The closing edge starts the rate unit, which forms the quotient one bit
//   a cycle, caps it at 999, extracts the decimal digits and then hands the
//   result over to the output register. sample.ready is low while the rate
//   unit is busy. Measurements alternate: the closing edge does not open
//   the next one.
//   Reset clears the edge detector and the measurement and loads
//   ticks_per_minute with 110592000. A stalled receiver holds the result;
//   a finished calculation then waits in the rate unit until the output
//   register is free, and further samples are taken only after that.
// ----------------------------------------------------------------------------
module pulse_period_to_bpm_display_top #(
    parameter int COUNT_WIDTH = pbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [pbd_pkg::TPM_W-1:0] cfg_wr_data,
    pbd_in_if.sink                    sample,
    pbd_out_if.source                 result
);
    import pbd_pkg::*;

    logic                   tpm_reg;
    logic [TPM_W-1:0]       tpm_value_reg;
    logic                   prev_reg;
    logic                   measuring_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   calc_busy_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic                   out_valid_reg;

    logic                   accept;
    logic                   falling;
    logic                   calc_start;
    logic                   load;

    pbd_ctrl_t              ctrl;
    pbd_status_t            status;
    pbd_result_t            calc;

    assign accept     = sample.valid && sample.ready;
    assign falling    = prev_reg && !sample.pulse_level;
    assign count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign calc_start = accept && measuring_reg && falling;
    assign load       = status.done && calc_busy_reg && (!out_valid_reg || result.ready);

    assign sample.ready = !calc_busy_reg;
    assign ctrl.start   = calc_start;
    assign ctrl.take    = load;

    // Marks that the register has been written since reset; the value
    // register itself carries its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg       <= 1'b0;
            tpm_value_reg <= TPM_RESET;
        end
        else if (cfg_wr_en)
        begin
            tpm_reg       <= 1'b1;
            tpm_value_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= 1'b0;
            measuring_reg <= 1'b0;
            count_reg     <= '0;
            calc_busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_reg <= sample.pulse_level;
                if (!measuring_reg)
                begin
                    if (falling)
                    begin
                        measuring_reg <= 1'b1;
                        count_reg     <= '0;
                    end
                end
                else
                begin
                    count_reg <= count_next;
                    if (falling)
                    begin
                        measuring_reg <= 1'b0;
                    end
                end
            end

            if (calc_start)
            begin
                calc_busy_reg <= 1'b1;
            end
            else if (load)
            begin
                calc_busy_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_start)
        begin
            period_reg <= PERIOD_W'(count_next);
        end
        if (load)
        begin
            result.period_ticks      <= period_reg;
            result.beats_per_minute  <= calc.rate;
            result.digit_hundreds    <= calc.hundreds;
            result.digit_tens        <= calc.tens;
            result.digit_ones        <= calc.ones;
            result.segments_hundreds <= seg_of(calc.hundreds);
            result.segments_tens     <= seg_of(calc.tens);
            result.segments_ones     <= seg_of(calc.ones);
        end
    end

    assign result.valid = out_valid_reg;

    pbd_rate_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .dividend (tpm_value_reg),
        .divisor  (count_next),
        .status   (status),
        .result   (calc)
    );

    // The digits taken from the rate unit must recompose the rate.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (RATE_W'(calc.hundreds) * RATE_W'(100) + RATE_W'(calc.tens) * RATE_W'(10)
                  + RATE_W'(calc.ones)) == calc.rate)
        else $error("rate digits do not recompose the rate");

    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (calc.rate <= RATE_MAX) && (calc.tens <= 4'd9) && (calc.ones <= 4'd9))
        else $error("rate or digit out of range");

    // A calculation starts only from an accepted closing edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(calc_busy_reg) |-> $past(accept && measuring_reg))
        else $error("rate unit started without a closing edge");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(calc_busy_reg && status.done))
        else $error("result presented without a finished calculation");

    assert property (@(posedge clk) disable iff (!rst_n)
        !tpm_reg |-> (tpm_value_reg == TPM_RESET))
        else $error("ticks per minute changed without a write");

endmodule
